[design/gmdck_pkg.sv]
// Package for the greedy minimum-distance corner keeper.
// Holds field widths, register indexes and the word and config types.
// No dependencies.
package gmdck_pkg;

  localparam int COORD_W = 12;
  localparam int SCORE_W = 32;
  localparam int MDS_W   = 24;
  localparam int MK_W    = 9;
  localparam int KC_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_STORE_DEPTH = 256;
  localparam int DEF_COORD_BITS  = 12;

  localparam logic [MDS_W-1:0] MDS_RESET = MDS_W'(100);
  localparam logic [MK_W-1:0]  MK_RESET  = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [MDS_W-1:0] min_dist_sq;
    logic [MK_W-1:0]  max_keep;
  } gmdck_cfg_t;

  typedef struct packed {
    logic               vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               close;
    logic               found;
    logic               taken;
    logic               lim;
  } gmdck_word_t;

endpackage

[design/gmdck_cell.sv]
// One cell of the corner keeper chain: holds one kept corner and its slot flags.
// Checks the passing candidate word against its corner and hands it on.
// Depends on gmdck_pkg.
module gmdck_cell
  import gmdck_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int CELL_IDX    = 0,
  localparam int CNT_W      = $clog2(STORE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  gmdck_cfg_t        cfg,
  input  gmdck_word_t       word_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output gmdck_word_t       word_o,
  output logic [CNT_W-1:0]  cnt_o
);

  localparam bit LAST_CELL = (CELL_IDX == STORE_DEPTH - 1);
  localparam int SQ_W      = 2 * COORD_W + 1;

  logic [COORD_W-1:0] st_x_r;
  logic [COORD_W-1:0] st_y_r;
  logic               st_vld_r;
  logic               blocked_r;
  gmdck_word_t        word_r;
  logic [CNT_W-1:0]   cnt_r;

  gmdck_word_t        word_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [2*COORD_W-1:0] sqx;
  logic [2*COORD_W-1:0] sqy;
  logic [SQ_W-1:0]    d2;
  logic               close_here;
  logic               first_empty;
  logic               mk_hit_here;
  logic               mk_hit_next;
  logic               blk_dec;
  logic               take;

  assign dx  = (word_i.x >= st_x_r) ? (word_i.x - st_x_r) : (st_x_r - word_i.x);
  assign dy  = (word_i.y >= st_y_r) ? (word_i.y - st_y_r) : (st_y_r - word_i.y);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign d2  = {1'b0, sqx} + {1'b0, sqy};

  assign close_here  = st_vld_r && (d2 < SQ_W'(cfg.min_dist_sq));
  assign first_empty = word_i.vld && !st_vld_r && !word_i.found;
  assign mk_hit_here = (cfg.max_keep != '0) && (32'(cfg.max_keep) <= 32'(CELL_IDX));
  assign mk_hit_next = LAST_CELL ||
                       ((cfg.max_keep != '0) && (32'(cfg.max_keep) <= 32'(CELL_IDX + 1)));
  assign blk_dec     = blocked_r || mk_hit_here;
  assign take        = first_empty && !blk_dec && !word_i.close;

  always_comb begin
    word_nxt       = word_i;
    cnt_nxt        = cnt_i;
    word_nxt.close = word_i.close || close_here;
    if (first_empty) begin
      word_nxt.found = 1'b1;
      word_nxt.taken = take;
      word_nxt.lim   = blk_dec || (take && mk_hit_next);
      cnt_nxt        = CNT_W'(CELL_IDX) + CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r   <= 1'b0;
      blocked_r  <= 1'b0;
      word_r.vld <= 1'b0;
    end else if (adv) begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
      if (word_i.vld) begin
        if (word_i.last) begin
          st_vld_r  <= 1'b0;
          blocked_r <= 1'b0;
        end else if (take) begin
          st_vld_r <= 1'b1;
        end else if (first_empty || (!st_vld_r && word_i.lim)) begin
          blocked_r <= blocked_r || blk_dec || word_i.lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      st_x_r <= word_i.x;
      st_y_r <= word_i.y;
    end
  end

  assign word_o = word_r;
  assign cnt_o  = cnt_r;

  a_slot_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_vld_r && blocked_r))
    else $error("cell holds a corner and is blocked");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && word_i.vld && word_i.last |=> !st_vld_r && !blocked_r)
    else $error("frame end did not clear cell");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(word_r.vld) && $stable(st_vld_r) && $stable(blocked_r))
    else $error("cell moved while stalled");

  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    word_r.vld && word_r.taken |-> word_r.found && !word_r.close)
    else $error("candidate taken without a free slot");

endmodule

[design/greedy_min_distance_corner_keep.sv]
// Greedy minimum-distance corner keeper. Candidates (sorted by descending score) enter a
// chain of STORE_DEPTH cells, one per kept corner. While in_ready is high, one word
// enters per cycle and each steps one cell per cycle; each cell compares the candidate
// with its corner, and the first free cell takes it if nothing was too close and the
// keep limit allows. Results leave through every cell register. A frame_end word clears
// each cell as it passes, so no clearing pass is needed. cfg_ready is always high; write
// registers only while no word is in the chain. Depends on gmdck_pkg and gmdck_cell.
module greedy_min_distance_corner_keep
  import gmdck_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MDS_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_pos_x,
  input  logic [COORD_W-1:0]   in_pos_y,
  input  logic [SCORE_W-1:0]   in_score_bits,
  input  logic                 in_frame_end,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic [SCORE_W-1:0]   out_score,
  output logic [KC_W-1:0]      out_kept_count,
  output logic                 out_limit_hit,
  output logic                 out_last_out
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CB_EFF = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << CB_EFF) - 64'd1);

  logic [MDS_W-1:0] mds_r;
  logic [MK_W-1:0]  mk_r;
  gmdck_cfg_t       cfg;
  logic             adv;

  gmdck_word_t      word_w [STORE_DEPTH+1];
  logic [CNT_W-1:0] cnt_w  [STORE_DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mds_r <= MDS_RESET;
      mk_r  <= MK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_DIST_SQ: mds_r <= cfg_data;
        CFG_MAX_KEEP:    mk_r  <= cfg_data[MK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.min_dist_sq = mds_r;
  assign cfg.max_keep    = mk_r;

  assign adv      = !word_w[STORE_DEPTH].vld || out_ready;
  assign in_ready = adv;

  always_comb begin
    word_w[0].vld   = in_valid;
    word_w[0].x     = in_pos_x & COORD_MASK;
    word_w[0].y     = in_pos_y & COORD_MASK;
    word_w[0].score = in_score_bits;
    word_w[0].last  = in_frame_end;
    word_w[0].close = 1'b0;
    word_w[0].found = 1'b0;
    word_w[0].taken = 1'b0;
    word_w[0].lim   = 1'b0;
  end
  assign cnt_w[0] = CNT_W'(STORE_DEPTH);

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    gmdck_cell #(
      .STORE_DEPTH (STORE_DEPTH),
      .CELL_IDX    (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cfg    (cfg),
      .word_i (word_w[i]),
      .cnt_i  (cnt_w[i]),
      .word_o (word_w[i+1]),
      .cnt_o  (cnt_w[i+1])
    );
  end

  assign out_valid      = word_w[STORE_DEPTH].vld;
  assign out_accepted   = word_w[STORE_DEPTH].taken;
  assign out_x          = word_w[STORE_DEPTH].x;
  assign out_y          = word_w[STORE_DEPTH].y;
  assign out_score      = word_w[STORE_DEPTH].score;
  assign out_kept_count = KC_W'(cnt_w[STORE_DEPTH]);
  assign out_limit_hit  = word_w[STORE_DEPTH].lim || !word_w[STORE_DEPTH].found;
  assign out_last_out   = word_w[STORE_DEPTH].last;

endmodule
